@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");

// Antecedent implies consequent on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Antecedent implies consequent on the same edge.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ design/isrt_pkg.sv @@
`default_nettype none

package isrt_pkg;

    // Number of cells in the chain (2 .. 64).
    localparam int CAPACITY = 8;
    localparam int DATA_W   = 32;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
        logic                     gt;   // empty, or holds a value above the incoming one
    } t_link;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     shift;
        logic signed [DATA_W-1:0] value;
    } t_ctl;

endpackage

`default_nettype wire

@@ design/isrt_cell.sv @@
`default_nettype none

module isrt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire isrt_pkg::t_ctl  i_ctl,
    input  wire isrt_pkg::t_link i_left,
    input  wire isrt_pkg::t_link i_right,
    output isrt_pkg::t_link      o_link
);
    import isrt_pkg::*;

    logic                     r_vld;
    logic                     n_vld;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     w_gt;

    // Empty cells count as larger than anything, so an arrival lands after equals.
    assign w_gt = !r_vld || (r_val > i_ctl.value);

    // Insert: first larger cell takes the new value, larger ones take the left value.
    // Drain: everything moves one cell toward the head.
    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        if (i_ctl.shift) begin
            n_vld = i_right.vld;
            n_val = i_right.val;
        end else if (i_ctl.ins && w_gt) begin
            if (i_left.gt) begin
                n_vld = i_left.vld;
                n_val = i_left.val;
            end else begin
                n_vld = 1'b1;
                n_val = i_ctl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Data holds no reset value; the valid bit guards it.
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_link.vld = r_vld;
    assign o_link.val = r_val;
    assign o_link.gt  = w_gt;

endmodule

`default_nettype wire

@@ design/insertion_sorter.sv @@
// Channel   Handshake                  Payload
// input     start & !busy accepts      i_value, i_last_item
// result    o_strobe, one cycle each   o_sorted_value, o_last_result, o_overflowed
//
// Items not marked last never stall the input; start may be high in every cycle.
// An item marked last is inserted unless the chain is full, then the chain
// drains one result per cycle from its head cell, so N held values give N results.
// busy is high during the drain; the next transaction is taken in the cycle
// after the final result. Results cannot be held off by the receiver.
// Reset (synchronous, active low) empties the chain and clears the drop flag.
`default_nettype none
`include "assert_macros.svh"

module insertion_sorter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire logic signed [isrt_pkg::DATA_W-1:0] i_value,
    input  wire logic                           i_last_item,
    output      logic                           o_strobe,
    output      logic signed [isrt_pkg::DATA_W-1:0] o_sorted_value,
    output      logic                           o_last_result,
    output      logic                           o_overflowed
);
    import isrt_pkg::*;

    t_link                 w_link  [CAPACITY];
    t_link                 w_left  [CAPACITY];
    t_link                 w_right [CAPACITY];
    t_ctl                  w_ctl;
    logic [CAPACITY-1:0]   w_vld;
    logic                  w_accept;
    logic                  w_full;
    logic                  r_draining;
    logic                  n_draining;
    logic                  r_drop;
    logic                  n_drop;

    assign w_accept = start && !r_draining;
    assign w_full   = w_link[CAPACITY-1].vld;

    assign w_ctl.ins   = w_accept && !w_full;
    assign w_ctl.shift = r_draining;
    assign w_ctl.value = i_value;

    // Cell chain; the head sees an empty, non-larger left neighbor, the tail an empty, larger right one.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '{vld: 1'b0, val: '0, gt: 1'b0};
        end else begin : g_body
            assign w_left[g] = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right[g] = '{vld: 1'b0, val: '0, gt: 1'b1};
        end else begin : g_mid
            assign w_right[g] = w_link[g+1];
        end
        assign w_vld[g] = w_link[g].vld;

        isrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_link  (w_link[g])
        );
    end

    // Drain control and drop flag.
    always_comb begin
        n_draining = r_draining;
        n_drop     = r_drop;
        if (r_draining) begin
            if (!w_link[1].vld) begin
                n_draining = 1'b0;
                n_drop     = 1'b0;
            end
        end else if (w_accept) begin
            n_drop = r_drop || w_full;
            if (i_last_item) begin
                n_draining = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_drop     <= 1'b0;
        end else begin
            r_draining <= n_draining;
            r_drop     <= n_drop;
        end
    end

    // Results come straight from the head cell.
    assign busy           = r_draining;
    assign o_strobe       = r_draining;
    assign o_sorted_value = w_link[0].val;
    assign o_last_result  = r_draining && !w_link[1].vld;
    assign o_overflowed   = r_draining && r_drop;

    // Held values always form a prefix of the chain.
    `ASSERT_ALWAYS(a_prefix, i_clk, i_rst_n, ((w_vld >> 1) & ~w_vld) == '0)
    // A drain never emits from an empty head.
    `ASSERT_SAME(a_head_vld, i_clk, i_rst_n, r_draining, w_link[0].vld)
    // After the final result the chain is empty and ready.
    `ASSERT_NEXT(a_done, i_clk, i_rst_n, o_strobe && o_last_result,
                 !busy && (w_vld == '0) && !r_drop)
    // A last item always starts a drain.
    `ASSERT_NEXT(a_start_drain, i_clk, i_rst_n, w_accept && i_last_item, busy)

endmodule

`default_nettype wire

@@ bench/sort_checker.sv @@
`timescale 1ns / 100ps

// Watches the item and result channels, predicts the sorted output of each
// list and compares every strobed result with the oldest prediction.
module sort_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic                               busy,
    input  wire logic signed [isrt_pkg::DATA_W-1:0] i_value,
    input  wire logic                               i_last_item,
    input  wire logic                               o_strobe,
    input  wire logic signed [isrt_pkg::DATA_W-1:0] o_sorted_value,
    input  wire logic                               o_last_result,
    input  wire logic                               o_overflowed,
    output int                                      fail_count,
    output int                                      outstanding
);

    import isrt_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_entry;

    // Expected results, oldest first
    t_sorted_entry expected_sorted[$];

    // Predicted contents of the chain
    logic signed [DATA_W-1:0] held_list[CAPACITY];
    int                       held_n;
    logic                     lost_items;

    // Insert one value behind all values <= it (or flag a loss if full); on a last item, flush the list
    function automatic void insert_and_flush(logic signed [DATA_W-1:0] v, logic mark_last);
        int            pos;
        t_sorted_entry entry;
        if (held_n >= CAPACITY) begin
            lost_items = 1'b1;
        end else begin
            pos = held_n;
            while (pos > 0 && held_list[pos-1] > v) begin
                held_list[pos] = held_list[pos-1];
                pos--;
            end
            held_list[pos] = v;
            held_n++;
        end
        if (mark_last) begin
            for (int k = 0; k < held_n; k++) begin
                entry.value = held_list[k];
                entry.last  = (k == held_n - 1);
                entry.ovf   = lost_items;
                expected_sorted.push_back(entry);
            end
            held_n     = 0;
            lost_items = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sorted_entry want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            held_n     = 0;
            lost_items = 1'b0;
            expected_sorted.delete();
            fail_count <= 0;
        end else begin
            // Result side: compare against the oldest prediction
            if (o_strobe) begin
                if (expected_sorted.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result: expected none, actual %0d %0b %0b",
                             $time, o_sorted_value, o_last_result, o_overflowed);
                end else begin
                    want = expected_sorted.pop_front();
                    if (o_sorted_value !== want.value) begin
                        errs++;
                        $display("%0t: sorted_value mismatch: expected %0d actual %0d",
                                 $time, want.value, o_sorted_value);
                    end
                    if (o_last_result !== want.last) begin
                        errs++;
                        $display("%0t: last_result mismatch: expected %0b actual %0b",
                                 $time, want.last, o_last_result);
                    end
                    if (o_overflowed !== want.ovf) begin
                        errs++;
                        $display("%0t: overflowed mismatch: expected %0b actual %0b",
                                 $time, want.ovf, o_overflowed);
                    end
                end
            end
            // Item side: one transaction per accepted start
            if (start && !busy)
                insert_and_flush(i_value, i_last_item);
            fail_count <= fail_count + errs;
        end
        outstanding <= expected_sorted.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import isrt_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int DIRECTED_ITEMS = 24;
    localparam int TOTAL_ITEMS    = 310;
    localparam int QUIET_ITEMS    = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_last_item = 1'b0;
    logic                     busy;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_last_result;
    logic                     o_overflowed;
    int                       fail_count;
    int                       outstanding;
    int                       quiet_cycles = 0;

    always #1 i_clk = ~i_clk;

    insertion_sorter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last_item    (i_last_item),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflowed   (o_overflowed)
    );

    sort_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last_item    (i_last_item),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_result  (o_last_result),
        .o_overflowed   (o_overflowed),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // Watchdog: ends the run after too many cycles without a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, optionally after a short idle burst; returns once taken
    task automatic drive_item(input logic signed [DATA_W-1:0] v, input logic mark_last,
                              input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_value     <= v;
        i_last_item <= mark_last;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Mix of wide random, clustered small and near-extreme values, and values with an all-0/all-1 upper half
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 8)) - 4;
            7:          return MIN_VAL + $urandom_range(0, 2);
            8:          return MAX_VAL - $urandom_range(0, 2);
            default:    return $signed({$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                        16'($urandom)});
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-item list holding the most negative value
        drive_item(MIN_VAL, 1'b1, 1'b1);
        // Extremes, zero and a repeated value
        drive_item(MAX_VAL, 1'b0, 1'b1);
        drive_item(MIN_VAL, 1'b0, 1'b1);
        drive_item(0, 1'b0, 1'b1);
        drive_item(-1, 1'b0, 1'b1);
        drive_item(0, 1'b0, 1'b1);
        drive_item(1, 1'b1, 1'b1);
        // Full chain, then a last item that is dropped
        for (int k = 0; k <= CAPACITY; k++)
            drive_item((k % 3) * 100 - k, k == CAPACITY, 1'b1);
        // Exactly full, strictly descending: every insert shifts the whole list
        for (int k = 0; k < CAPACITY; k++)
            drive_item(1000 - k * 300, k == CAPACITY - 1, 1'b0);
        wait_drained();

        // Random lists, some long enough to overflow
        while (sent < TOTAL_ITEMS - DIRECTED_ITEMS) begin
            if (sent < TOTAL_ITEMS - DIRECTED_ITEMS - QUIET_ITEMS && $urandom_range(0, 7) == 0)
                wait_drained();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
                                              : $urandom_range(1, CAPACITY);
            for (int k = 0; k < len; k++) begin
                drive_item(pick_value(), k == len - 1,
                           sent < TOTAL_ITEMS - DIRECTED_ITEMS - QUIET_ITEMS);
                sent++;
            end
        end

        // Drain and let the chain settle
        wait_drained();
        repeat (CAPACITY + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/isrt_pkg.sv
design/isrt_cell.sv
design/insertion_sorter.sv
bench/sort_checker.sv
bench/testbench.sv
